[src/spr_pkg.sv]
// Shared definitions for the segment pair relation block.
// Used by spr_cross and segment_pair_relation; depends on nothing else.
package spr_pkg;

  localparam int COORD_WIDTH_DEFAULT = 32;

  localparam logic [1:0] REL_APART    = 2'd0;
  localparam logic [1:0] REL_CROSSING = 2'd1;
  localparam logic [1:0] REL_COLINEAR = 2'd2;
  localparam logic [1:0] REL_OVERLAP  = 2'd3;

  // Sign of one cross product: both flags low means the three points are colinear.
  typedef struct packed {
    logic pos;
    logic neg;
  } orient_t;

endpackage

[src/spr_cross.sv]
// Two-stage orientation unit: multiplies the cross terms, then compares them.
// Depends on spr_pkg for orient_t.
module spr_cross #(
  parameter int COORD_WIDTH = spr_pkg::COORD_WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [COORD_WIDTH:0]   ux,
  input  logic signed [COORD_WIDTH:0]   uy,
  input  logic signed [COORD_WIDTH:0]   vx,
  input  logic signed [COORD_WIDTH:0]   vy,
  output spr_pkg::orient_t              orient
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;

  logic signed [PW-1:0] mul_a;
  logic signed [PW-1:0] mul_b;
  logic signed [PW-1:0] prod_a;
  logic signed [PW-1:0] prod_b;

  assign mul_a = PW'(ux) * PW'(vy);
  assign mul_b = PW'(uy) * PW'(vx);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_a     <= mul_a;
      prod_b     <= mul_b;
      orient.pos <= (prod_a > prod_b);
      orient.neg <= (prod_a < prod_b);
    end
  end

endmodule

[src/segment_pair_relation.sv]
// Classifies two line segments as apart, crossing, colinear disjoint or overlapping.
// Depends on spr_pkg and instantiates four spr_cross orientation units.
//
// Usage:
//   One segment pair is a word on the input channel (in_valid / in_ready),
//   eight signed coordinates. Each word yields exactly one relation_code word
//   on the output channel (out_valid / out_ready), in order.
//   The pipeline has four register stages: coordinate differences and range
//   bounds, cross-term products, product compare, and classification into the
//   output register. The accepting edge loads the first stage, and a word then
//   moves through the product, compare and output registers in order. One word
//   enters per cycle as long as the receiver takes words; the depth is set by
//   the multiply and the wide compare, each given a stage of its own.
//   When the receiver stalls with a word waiting, the whole pipeline holds and
//   in_ready falls; an empty output register never blocks the pipeline.
//   Reset clears the valid bits of every stage; the data registers are not reset.
module segment_pair_relation #(
  parameter int COORD_WIDTH = spr_pkg::COORD_WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] first_start_x,
  input  logic signed [COORD_WIDTH-1:0] first_start_y,
  input  logic signed [COORD_WIDTH-1:0] first_end_x,
  input  logic signed [COORD_WIDTH-1:0] first_end_y,
  input  logic signed [COORD_WIDTH-1:0] second_start_x,
  input  logic signed [COORD_WIDTH-1:0] second_start_y,
  input  logic signed [COORD_WIDTH-1:0] second_end_x,
  input  logic signed [COORD_WIDTH-1:0] second_end_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    relation_code
);

  localparam int DW = COORD_WIDTH + 1;

  function automatic logic signed [DW-1:0] diff(input logic signed [COORD_WIDTH-1:0] b,
                                                input logic signed [COORD_WIDTH-1:0] a);
    diff = DW'(b) - DW'(a);
  endfunction

  logic adv;
  logic v1, v2, v3;

  // Stage 1 registers.
  logic signed [DW-1:0] ba_x, ba_y, ca_x, ca_y, da_x, da_y;
  logic signed [DW-1:0] dc_x, dc_y, ac_x, ac_y, bc_x, bc_y;
  logic signed [COORD_WIDTH-1:0] fx_min, fx_max, fy_min, fy_max;
  logic signed [COORD_WIDTH-1:0] sx_min, sx_max, sy_min, sy_max;

  // Range test travels beside the orientation units.
  logic meet2, meet3;

  spr_pkg::orient_t o1, o2, o3, o4;
  logic colinear3;
  logic [1:0] relation_next;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ba_x <= diff(first_end_x, first_start_x);
      ba_y <= diff(first_end_y, first_start_y);
      ca_x <= diff(second_start_x, first_start_x);
      ca_y <= diff(second_start_y, first_start_y);
      da_x <= diff(second_end_x, first_start_x);
      da_y <= diff(second_end_y, first_start_y);
      dc_x <= diff(second_end_x, second_start_x);
      dc_y <= diff(second_end_y, second_start_y);
      ac_x <= diff(first_start_x, second_start_x);
      ac_y <= diff(first_start_y, second_start_y);
      bc_x <= diff(first_end_x, second_start_x);
      bc_y <= diff(first_end_y, second_start_y);

      fx_min <= (first_start_x < first_end_x) ? first_start_x : first_end_x;
      fx_max <= (first_start_x < first_end_x) ? first_end_x : first_start_x;
      fy_min <= (first_start_y < first_end_y) ? first_start_y : first_end_y;
      fy_max <= (first_start_y < first_end_y) ? first_end_y : first_start_y;
      sx_min <= (second_start_x < second_end_x) ? second_start_x : second_end_x;
      sx_max <= (second_start_x < second_end_x) ? second_end_x : second_start_x;
      sy_min <= (second_start_y < second_end_y) ? second_start_y : second_end_y;
      sy_max <= (second_start_y < second_end_y) ? second_end_y : second_start_y;

      meet2 <= !(sx_max < fx_min) && !(fx_max < sx_min) &&
               !(sy_max < fy_min) && !(fy_max < sy_min);
      meet3 <= meet2;

      relation_code <= relation_next;
    end
  end

  spr_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross_1 (
    .clk(clk), .en(adv), .ux(ba_x), .uy(ba_y), .vx(ca_x), .vy(ca_y), .orient(o1)
  );
  spr_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross_2 (
    .clk(clk), .en(adv), .ux(ba_x), .uy(ba_y), .vx(da_x), .vy(da_y), .orient(o2)
  );
  spr_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross_3 (
    .clk(clk), .en(adv), .ux(dc_x), .uy(dc_y), .vx(ac_x), .vy(ac_y), .orient(o3)
  );
  spr_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross_4 (
    .clk(clk), .en(adv), .ux(dc_x), .uy(dc_y), .vx(bc_x), .vy(bc_y), .orient(o4)
  );

  assign colinear3 = (o1 == '0) && (o2 == '0) && (o3 == '0) && (o4 == '0);

  always_comb begin
    if (colinear3) begin
      relation_next = meet3 ? spr_pkg::REL_OVERLAP : spr_pkg::REL_COLINEAR;
    end else if ((o1 != o2) && (o3 != o4)) begin
      relation_next = spr_pkg::REL_CROSSING;
    end else begin
      relation_next = spr_pkg::REL_APART;
    end
  end

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && !v1)
    else $error("pipeline not empty after reset");

  // An accepted word occupies the first stage on the next cycle.
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> v1)
    else $error("accepted word lost at stage one");

  // A cross product can never be both above and below zero.
  a_orient_sane: assert property (@(posedge clk) disable iff (rst)
    v3 |-> !(o1.pos && o1.neg) && !(o2.pos && o2.neg) &&
           !(o3.pos && o3.neg) && !(o4.pos && o4.neg))
    else $error("orientation flags contradict");

  // Fully colinear pairs always leave as colinear or overlapping.
  a_colinear_code: assert property (@(posedge clk) disable iff (rst)
    (adv && v3 && colinear3) |=>
      (relation_code == spr_pkg::REL_OVERLAP || relation_code == spr_pkg::REL_COLINEAR))
    else $error("colinear pair given a non-colinear code");

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for segment_pair_relation: directed and random segment pairs.
// Depends on spr_pkg and the segment_pair_relation RTL only.
module tb;

  localparam int CW          = spr_pkg::COORD_WIDTH_DEFAULT;
  localparam int LATENCY     = 4;
  localparam int HOLD_CYCLES = 150;
  localparam int RANDOM_PAIRS = 390;

  typedef logic signed [CW-1:0] coord_t;

  localparam coord_t C_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam coord_t C_MAX = {1'b0, {(CW-1){1'b1}}};

  typedef struct {
    coord_t fsx, fsy, fex, fey;
    coord_t ssx, ssy, sex, sey;
  } seg_pair_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  coord_t     first_start_x, first_start_y, first_end_x, first_end_y;
  coord_t     second_start_x, second_start_y, second_end_x, second_end_y;
  logic       out_valid;
  logic       out_ready;
  logic [1:0] relation_code;

  logic [1:0] pending_codes[$];
  logic [1:0] want_code;
  int         fail_count = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  bit         hold_request = 1'b0;

  segment_pair_relation dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .first_start_x  (first_start_x),
    .first_start_y  (first_start_y),
    .first_end_x    (first_end_x),
    .first_end_y    (first_end_y),
    .second_start_x (second_start_x),
    .second_start_y (second_start_y),
    .second_end_x   (second_end_x),
    .second_end_y   (second_end_y),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .relation_code  (relation_code)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Sign of (q - p) x (r - p), computed wide enough to be exact.
  function automatic spr_pkg::orient_t orientation(coord_t px, coord_t py, coord_t qx,
                                                   coord_t qy, coord_t rx, coord_t ry);
    logic signed [67:0] wpx, wpy, wqx, wqy, wrx, wry, lhs, rhs, gap;
    spr_pkg::orient_t o;
    wpx = px; wpy = py; wqx = qx; wqy = qy; wrx = rx; wry = ry;
    lhs = (wqx - wpx) * (wry - wpy);
    rhs = (wqy - wpy) * (wrx - wpx);
    gap = lhs - rhs;
    o.pos = (gap > 0);
    o.neg = (gap < 0);
    return o;
  endfunction

  function automatic bit ranges_touch(coord_t a0, coord_t a1, coord_t b0, coord_t b1);
    coord_t alo, ahi, blo, bhi;
    alo = (a0 < a1) ? a0 : a1;
    ahi = (a0 < a1) ? a1 : a0;
    blo = (b0 < b1) ? b0 : b1;
    bhi = (b0 < b1) ? b1 : b0;
    return !(bhi < alo) && !(ahi < blo);
  endfunction

  function automatic logic [1:0] classify_pair(seg_pair_t s);
    spr_pkg::orient_t r1, r2, r3, r4;
    r1 = orientation(s.fsx, s.fsy, s.fex, s.fey, s.ssx, s.ssy);
    r2 = orientation(s.fsx, s.fsy, s.fex, s.fey, s.sex, s.sey);
    r3 = orientation(s.ssx, s.ssy, s.sex, s.sey, s.fsx, s.fsy);
    r4 = orientation(s.ssx, s.ssy, s.sex, s.sey, s.fex, s.fey);
    if (r1 == 2'b00 && r2 == 2'b00 && r3 == 2'b00 && r4 == 2'b00) begin
      if (ranges_touch(s.fsx, s.fex, s.ssx, s.sex) && ranges_touch(s.fsy, s.fey, s.ssy, s.sey))
        return spr_pkg::REL_OVERLAP;
      return spr_pkg::REL_COLINEAR;
    end
    if (r1 != r2 && r3 != r4)
      return spr_pkg::REL_CROSSING;
    return spr_pkg::REL_APART;
  endfunction

  function automatic seg_pair_t mk(coord_t ax, coord_t ay, coord_t bx, coord_t by,
                                   coord_t cx, coord_t cy, coord_t dx, coord_t dy);
    seg_pair_t s;
    s.fsx = ax; s.fsy = ay; s.fex = bx; s.fey = by;
    s.ssx = cx; s.ssy = cy; s.sex = dx; s.sey = dy;
    return s;
  endfunction

  function automatic int span_int(int unsigned span);
    return int'(longint'($urandom_range(2 * span)) - longint'(span));
  endfunction

  function automatic coord_t pick_extreme();
    case ($urandom_range(5))
      0: return C_MIN;
      1: return C_MAX;
      2: return coord_t'(0);
      3: return coord_t'(-1);
      4: return coord_t'(1);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Most pairs are built to land on or near shared lines, since fully random
  // coordinates almost never produce the colinear or touching cases.
  function automatic seg_pair_t random_pair();
    seg_pair_t s;
    coord_t px[4], py[4];
    int base_x, base_y, step_x, step_y, k;
    int unsigned kspan;
    int mode;
    mode = $urandom_range(99);
    if (mode < 20) begin
      s = mk(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
             coord_t'($urandom), coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
    end else if (mode < 40) begin
      s = mk(span_int(6), span_int(6), span_int(6), span_int(6),
             span_int(6), span_int(6), span_int(6), span_int(6));
    end else if (mode < 85) begin
      base_x = span_int(1 << 30);
      base_y = span_int(1 << 30);
      step_x = ($urandom_range(3) == 0) ? 0 : span_int(1 << 15);
      step_y = ($urandom_range(3) == 0) ? 0 : span_int(1 << 15);
      kspan  = $urandom_range(1) ? 4 : (1 << 14);
      for (int i = 0; i < 4; i++) begin
        k = span_int(kspan);
        px[i] = base_x + k * step_x;
        py[i] = base_y + k * step_y;
      end
      // Some of these only put the second start on the first line.
      if (mode >= 70) begin
        px[3] = px[2] + span_int(1000);
        py[3] = py[2] + span_int(1000);
      end
      s = mk(px[0], py[0], px[1], py[1], px[2], py[2], px[3], py[3]);
    end else begin
      s = mk(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
             pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme());
    end
    return s;
  endfunction

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Predict each accepted word from the values presented at the accepting edge.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready)
      pending_codes.push_back(classify_pair(mk(first_start_x, first_start_y, first_end_x,
          first_end_y, second_start_x, second_start_y, second_end_x, second_end_y)));
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_codes.size() == 0) begin
        $error("unexpected relation_code word %0d with nothing pending", relation_code);
        fail_count++;
      end else begin
        want_code = pending_codes.pop_front();
        if (relation_code !== want_code) begin
          $error("relation_code mismatch: expected %0d, actual %0d", want_code, relation_code);
          fail_count++;
        end
      end
    end
  end

  task automatic send_pair(seg_pair_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    first_start_x  <= s.fsx;
    first_start_y  <= s.fsy;
    first_end_x    <= s.fex;
    first_end_y    <= s.fey;
    second_start_x <= s.ssx;
    second_start_y <= s.ssy;
    second_end_x   <= s.sex;
    second_end_y   <= s.sey;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_cases();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_pair(mk(0, 0, 10, 10, 0, 10, 10, 0));
    send_pair(mk(-1, -1, 1, 1, -1, 1, 1, -1));
    send_pair(mk(0, 0, 10, 0, 0, 5, 10, 5));
    send_pair(mk(0, 0, 1, 1, 5, 0, 6, -3));
    send_pair(mk(0, 0, 2, 2, 5, 5, 9, 9));
    send_pair(mk(0, 0, 6, 6, 3, 3, 9, 9));
    // Colinear segments meeting only at one endpoint.
    send_pair(mk(0, 0, 4, 0, 4, 0, 8, 0));
    // An endpoint on the other segment, and a shared corner.
    send_pair(mk(0, 0, 10, 0, 5, 0, 5, 7));
    send_pair(mk(0, 0, 4, 4, 4, 4, 8, 0));
    // Degenerate segments: on the line, off it, coincident and separate points.
    send_pair(mk(0, 0, 8, 8, 3, 3, 3, 3));
    send_pair(mk(0, 0, 8, 8, 3, 5, 3, 5));
    send_pair(mk(7, 7, 7, 7, 7, 7, 7, 7));
    send_pair(mk(1, 2, 1, 2, 3, 4, 3, 4));
    send_pair(mk(C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN));
    send_pair(mk(C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX));
    send_pair(mk(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN));
    send_pair(mk(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX));
    send_pair(mk(C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX - 1));
    send_pair(mk(3, C_MIN, 3, -1, 3, 0, 3, C_MAX));
    send_pair(mk(C_MIN, 5, -1, 5, 0, 5, C_MAX, 5));
    send_pair(mk(C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX));
    send_pair(mk(C_MAX, C_MIN, C_MIN, C_MAX, 0, 0, -1, -1));
    wait_drained();
  endtask

  task automatic test_random_pairs(int send_pct, int recv_pct, int count);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < count; i++)
      send_pair(random_pair());
    wait_drained();
  endtask

  // The receiver holds off while words keep coming, so the pipeline fills and
  // in_ready has to drop.
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = 1'b1;
    for (int i = 0; i < 40; i++)
      send_pair(random_pair());
    wait_drained();
  endtask

  initial begin
    rst            <= 1'b1;
    in_valid       <= 1'b0;
    first_start_x  <= '0;
    first_start_y  <= '0;
    first_end_x    <= '0;
    first_end_y    <= '0;
    second_start_x <= '0;
    second_start_y <= '0;
    second_end_x   <= '0;
    second_end_y   <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_random_pairs(7, 46, RANDOM_PAIRS);
    test_random_pairs(46, 7, RANDOM_PAIRS);
    test_random_pairs(0, 0, RANDOM_PAIRS);
    test_output_backpressure();

    recv_idle_pct = 0;
    repeat (4 * LATENCY) @(posedge clk);
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #(12 * 300_000);
    $display("TEST FAILED");
    $finish;
  end

endmodule
